// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the ready-queue scheduler.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/prsq_pkg.sv -----
// Types and codes for the priority ready-queue scheduler.
// No dependencies; used by the controller, datapath and top level.
package prsq_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SET_PRI = 2'd2,
    OP_SCHED   = 2'd3
  } op_kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOCHANGE = 3'd1,
    ST_NOTHEAD  = 3'd2,
    ST_NONE     = 3'd3,
    ST_BUSY     = 3'd4
  } status_t;

  // Controller states
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the request beat
    logic execute;  // apply the operation and load the result
  } ctrl_cmd_t;

endpackage

// ----- rtl/prsq_if.sv -----
// Request and response channel interfaces of the ready-queue scheduler.
// No dependencies.
interface prsq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] thread_id;
  logic [3:0] new_priority;

  modport source (output valid, kind, thread_id, new_priority, input ready);
  modport sink   (input valid, kind, thread_id, new_priority, output ready);
endinterface

interface prsq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] chosen_thread;
  logic [3:0] level;

  modport source (output valid, status, chosen_thread, level, input ready);
  modport sink   (input valid, status, chosen_thread, level, output ready);
endinterface

// ----- rtl/prsq_ctrl.sv -----
// Controller of the ready-queue scheduler: sequences capture and execute,
// tracks the output register. Depends on prsq_pkg.
module prsq_ctrl
  import prsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        rsp_ready,
  output logic        rsp_valid,
  output ctrl_cmd_t   cmd,
  output ctrl_state_t state
);

  ctrl_state_t state_next;
  logic        out_full;
  logic        out_full_next;

  // State and output-full registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CS_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    req_ready   = 1'b0;
    unique case (state)
      CS_IDLE: begin
        // no beat is taken while reset is held
        req_ready   = !rst;
        cmd.capture = req_valid && !rst;
        if (cmd.capture) state_next = CS_EXEC;
      end
      CS_EXEC: begin
        // wait for a free output slot
        cmd.execute = !out_full || rsp_ready;
        if (cmd.execute) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
    if (cmd.execute) out_full_next = 1'b1;
    else if (rsp_ready) out_full_next = 1'b0;
    else out_full_next = out_full;
  end

  assign rsp_valid = out_full;

endmodule

// ----- rtl/prsq_datapath.sv -----
// Datapath of the ready-queue scheduler: thread table, level queues,
// operation logic and result register. Depends on prsq_pkg.
module prsq_datapath
  import prsq_pkg::*;
#(
  parameter int THREADS = 8,
  parameter int LEVELS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  logic [1:0] kind,
  input  logic [2:0] thread_id,
  input  logic [3:0] new_priority,
  output logic [2:0] status,
  output logic [2:0] chosen_thread,
  output logic [3:0] level
);

  localparam int TIW = $clog2(THREADS);       // thread index width
  localparam int PW  = $clog2(THREADS + 1);   // link width, holds null
  localparam int LW  = $clog2(LEVELS);        // level index width
  localparam logic [PW-1:0] NIL = PW'(THREADS);
  localparam logic [LW-1:0] LVL_MAX = LW'(LEVELS - 1);

  // Captured request
  op_kind_t   op_kind;
  logic [2:0] op_tid;
  logic [3:0] op_np;

  // Thread table and level queues
  logic [LW-1:0]  thread_priority [THREADS];
  logic           thread_ready    [THREADS];
  logic [PW-1:0]  thread_next     [THREADS];
  logic [TIW-1:0] level_head      [LEVELS];
  logic [TIW-1:0] level_tail      [LEVELS];
  logic [LEVELS-1:0] level_busy;  // level queue not empty

  // Decoded operands
  logic           tid_ok;
  logic [TIW-1:0] idx;
  logic [LW-1:0]  pri;
  logic           rdy;
  logic [PW-1:0]  nxt;
  logic [LW-1:0]  np_sat;
  logic           found;
  logic [LW-1:0]  first_lvl;
  logic [LW-1:0]  head_addr;
  logic [TIW-1:0] head_val;
  logic [TIW-1:0] tail_val;

  // Operation outcome
  status_t    res_status;
  logic [2:0] res_thread;
  logic [3:0] res_level;
  logic       do_enq;
  logic       do_deq;
  logic       do_set;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind <= op_kind_t'(kind);
      op_tid  <= thread_id;
      op_np   <= new_priority;
    end
  end

  // Operand reads
  always_comb begin
    tid_ok = int'(op_tid) < THREADS;
    idx    = TIW'(op_tid);
    pri    = thread_priority[idx];
    rdy    = thread_ready[idx];
    nxt    = thread_next[idx];
    tail_val = level_tail[pri];
    if (int'(op_np) >= LEVELS) np_sat = LVL_MAX;
    else np_sat = LW'(op_np);
  end

  // Lowest non-empty level
  always_comb begin
    found     = 1'b0;
    first_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (level_busy[i]) begin
        found     = 1'b1;
        first_lvl = LW'(i);
      end
    end
    head_addr = (op_kind == OP_SCHED) ? first_lvl : pri;
    head_val  = level_head[head_addr];
  end

  // Operation decode
  always_comb begin
    res_status = ST_NOCHANGE;
    res_thread = '0;
    res_level  = '0;
    do_enq     = 1'b0;
    do_deq     = 1'b0;
    do_set     = 1'b0;
    unique case (op_kind)
      OP_SCHED: begin
        if (found) begin
          res_status = ST_OK;
          res_thread = 3'(head_val);
          res_level  = 4'(first_lvl);
        end else begin
          res_status = ST_NONE;
        end
      end
      OP_ENQUEUE: begin
        if (tid_ok && !rdy) begin
          res_status = ST_OK;
          do_enq     = 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (tid_ok && rdy) begin
          if (head_val != idx) begin
            res_status = ST_NOTHEAD;
          end else begin
            res_status = ST_OK;
            do_deq     = 1'b1;
          end
        end
      end
      OP_SET_PRI: begin
        if (tid_ok) begin
          res_level = 4'(pri);
          if (rdy) begin
            res_status = ST_BUSY;
          end else begin
            res_status = ST_OK;
            do_set     = 1'b1;
          end
        end
      end
      default: res_status = ST_NOCHANGE;
    endcase
  end

  // Control state of the table: ready flags, priorities, queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        thread_ready[i]    <= 1'b0;
        thread_priority[i] <= '0;
      end
      level_busy <= '0;
    end else if (cmd.execute) begin
      if (do_enq) begin
        thread_ready[idx] <= 1'b1;
        level_busy[pri]   <= 1'b1;
      end
      if (do_deq) begin
        thread_ready[idx] <= 1'b0;
        if (nxt == NIL) level_busy[pri] <= 1'b0;
      end
      if (do_set) thread_priority[idx] <= np_sat;
    end
  end

  // Links and queue pointers; only read while their level is occupied
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (do_enq) begin
        if (level_busy[pri]) thread_next[tail_val] <= PW'(op_tid);
        else level_head[pri] <= idx;
        level_tail[pri]  <= idx;
        thread_next[idx] <= NIL;
      end
      if (do_deq) begin
        level_head[pri]  <= TIW'(nxt);
        thread_next[idx] <= NIL;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status        <= res_status;
      chosen_thread <= res_thread;
      level         <= res_level;
    end
  end

endmodule

// ----- rtl/priority_ready_queue_scheduler_unit.sv -----
// Top level of the fixed-priority FIFO ready-queue scheduler.
// Depends on prsq_pkg, prsq_if, prsq_ctrl, prsq_datapath, assert_macros.svh.
`include "assert_macros.svh"

// Each request beat (enqueue, dequeue, set priority, schedule) passes through
// the controller's two states: the idle state captures the beat and the
// execute state reads the thread table, applies the operation and loads the
// result register; a new beat is taken only once the previous one executed.
// Schedule finds the lowest occupied level through a priority encoder over
// per-level occupancy flags. A result waiting in the output register does
// not block the next request beat from being captured; the execute cycle
// waits until the result slot is free. Reset clears ready flags,
// priorities and occupancy.
module priority_ready_queue_scheduler_unit
  import prsq_pkg::*;
#(
  parameter int THREADS = 8,
  parameter int LEVELS  = 16
) (
  input logic       clk,
  input logic       rst,
  prsq_req_if.sink   req,
  prsq_rsp_if.source rsp
);

  ctrl_cmd_t   cmd;
  ctrl_state_t state;

  // Controller
  prsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd),
    .state     (state)
  );

  // Datapath
  prsq_datapath #(
    .THREADS (THREADS),
    .LEVELS  (LEVELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (req.kind),
    .thread_id     (req.thread_id),
    .new_priority  (req.new_priority),
    .status        (rsp.status),
    .chosen_thread (rsp.chosen_thread),
    .level         (rsp.level)
  );

  // Checks
  `ASSERT_NEXT(a_capture_then_exec, clk, rst, req.valid && req.ready, state == CS_EXEC)
  `ASSERT_NOW(a_exec_slot_free, clk, rst, cmd.execute, !rsp.valid || rsp.ready)
  `ASSERT_NEXT(a_exec_then_valid, clk, rst, cmd.execute, rsp.valid)
  `ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, !(cmd.capture && cmd.execute))

endmodule
